FILE: hw/rtl/modbus_rtu_master_transaction_defines.svh
// Assertion macros shared by the checker of the Modbus RTU master.
// Holds only the include guard and the macro definitions.
`ifndef MODBUS_RTU_MASTER_TRANSACTION_DEFINES_SVH
`define MODBUS_RTU_MASTER_TRANSACTION_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define MRM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("modbus master assertion failed");

// Property checked on every clock edge, reset included.
`define MRM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("modbus master assertion failed during reset");

`endif

FILE: hw/rtl/mrm_pkg.sv
// Package of the Modbus RTU master: codes, state type, control structs
// and the CRC-16 byte step. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mrm_pkg;

  // Input word kinds.
  localparam logic [2:0] K_SEND = 3'd0;
  localparam logic [2:0] K_RX   = 3'd1;
  localparam logic [2:0] K_END  = 3'd2;
  localparam logic [2:0] K_TICK = 3'd3;
  localparam logic [2:0] K_LOAD = 3'd4;
  localparam logic [2:0] K_READ = 3'd5;

  // Result word kinds.
  localparam logic [1:0] R_TX     = 2'd0;
  localparam logic [1:0] R_STATUS = 2'd1;
  localparam logic [1:0] R_DATA   = 2'd2;

  // Transaction status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_LENGTH   = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_DEVICE   = 3'd4;
  localparam logic [2:0] ST_FUNCTION = 3'd5;
  localparam logic [2:0] ST_CRC      = 3'd6;
  localparam logic [2:0] ST_TIMEOUT  = 3'd7;

  // Modbus function codes with a register rule.
  localparam logic [7:0] FN_READ_COILS = 8'd1;
  localparam logic [7:0] FN_READ_HOLD  = 8'd3;
  localparam logic [7:0] FN_WRITE_COIL = 8'd5;
  localparam logic [7:0] FN_WRITE_REG  = 8'd6;

  // Configuration register byte addresses.
  localparam logic [2:0] A_JOIN    = 3'd0;
  localparam logic [2:0] A_TIMEOUT = 3'd4;

  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRC,
    S_TX,
    S_CHECK,
    S_SEARCH,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic crc_en;
    logic tx_next;
    logic check;
    logic search;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go_crc;
    logic go_out;
    logic go_check;
    logic crc_last;
    logic tx_last;
    logic store_req;
    logic search_done;
  } dp_stat_t;

  // One byte of the reflected Modbus CRC-16.
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/modbus_rtu_master_transaction.sv
// Modbus RTU master for one transaction at a time.
// Input channel in_valid/in_stall carries one word per item (kind plus fields);
// output channel out_valid/out_stall carries result words. Configuration
// registers join_address (0x0) and reply_timeout_ticks (0x4) sit on an APB port.
// Steps per input word, one word in work at a time:
//   send request: accept, CRC over the six request bytes, then
//     8 transmit words, one a cycle while the receiver does not stall;
//   frame end, reply pending, bytes collected: accept, check, a search of up
//     to TABLE_ENTRIES entries (one a cycle) when storing, then 1 status word;
//   table read and timing-out tick: accept, then 1 word;
//   received byte, load, other ticks and other words: accept, no word.
// While a result word waits for the receiver, in_stall stays high; a stalled
// word holds its value. Reset clears the transaction, the collected frame,
// the register table and the joined flag, and loads the timeout with 50.
// Depends on mrm_pkg, mrm_ctrl and mrm_datapath.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_master_transaction #(
  parameter int TABLE_ENTRIES   = 12,
  parameter int MAX_FRAME_BYTES = 1024
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [2:0]  kind,
  input  wire  [7:0]  dev_code,
  input  wire  [7:0]  fun_code,
  input  wire  [15:0] reg_address,
  input  wire  [15:0] write_value,
  input  wire  [7:0]  rx_byte,
  input  wire  [3:0]  entry_index,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  tx_byte,
  output logic        last_of_run,
  output logic [2:0]  status,
  output logic [15:0] entry_value,
  output logic        device_joined
);

  logic [15:0]        join_address;
  logic [15:0]        reply_timeout_ticks;
  logic               cfg_wr;
  mrm_pkg::ctrl_cmd_t cmd;
  mrm_pkg::dp_stat_t  stat;

  // Configuration registers, decoded on the word address bit.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      join_address        <= 16'd0;
      reply_timeout_ticks <= 16'd50;
    end else if (cfg_wr) begin
      if (paddr[2]) reply_timeout_ticks <= pwdata[15:0];
      else          join_address        <= pwdata[15:0];
    end
  end

  assign prdata = paddr[2] ? {16'h0000, reply_timeout_ticks} : {16'h0000, join_address};

  mrm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  mrm_datapath #(
    .TABLE_ENTRIES   (TABLE_ENTRIES),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .stat                (stat),
    .join_address        (join_address),
    .reply_timeout_ticks (reply_timeout_ticks),
    .kind                (kind),
    .dev_code            (dev_code),
    .fun_code            (fun_code),
    .reg_address         (reg_address),
    .write_value         (write_value),
    .rx_byte             (rx_byte),
    .entry_index         (entry_index),
    .result_kind         (result_kind),
    .tx_byte             (tx_byte),
    .last_of_run         (last_of_run),
    .status              (status),
    .entry_value         (entry_value),
    .device_joined       (device_joined)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/mrm_ctrl.sv
// Controller state machine of the Modbus RTU master.
// Depends on mrm_pkg; drives the handshakes and commands the datapath.
`timescale 1ns / 1ps
`default_nettype none

module mrm_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire                out_stall,
  output mrm_pkg::ctrl_cmd_t cmd,
  input  mrm_pkg::dp_stat_t  stat
);

  mrm_pkg::state_t state;
  mrm_pkg::state_t state_next;
  logic            out_take;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands. The input is held off during reset.
  always_comb begin
    state_next  = state;
    in_stall    = rst || (state != mrm_pkg::S_IDLE);
    out_valid   = (state == mrm_pkg::S_TX) || (state == mrm_pkg::S_OUT);
    out_take    = out_valid && !out_stall;
    cmd.accept  = in_valid && !in_stall;
    cmd.crc_en  = (state == mrm_pkg::S_CRC);
    cmd.tx_next = (state == mrm_pkg::S_TX) && out_take;
    cmd.check   = (state == mrm_pkg::S_CHECK);
    cmd.search  = (state == mrm_pkg::S_SEARCH);
    unique case (state)
      mrm_pkg::S_IDLE: begin
        if (cmd.accept) begin
          if (stat.go_crc) state_next = mrm_pkg::S_CRC;
          else if (stat.go_out) state_next = mrm_pkg::S_OUT;
          else if (stat.go_check) state_next = mrm_pkg::S_CHECK;
        end
      end
      mrm_pkg::S_CRC: begin
        if (stat.crc_last) state_next = mrm_pkg::S_TX;
      end
      mrm_pkg::S_TX: begin
        if (out_take && stat.tx_last) state_next = mrm_pkg::S_IDLE;
      end
      mrm_pkg::S_CHECK: begin
        state_next = stat.store_req ? mrm_pkg::S_SEARCH : mrm_pkg::S_OUT;
      end
      mrm_pkg::S_SEARCH: begin
        if (stat.search_done) state_next = mrm_pkg::S_OUT;
      end
      mrm_pkg::S_OUT: begin
        if (out_take) state_next = mrm_pkg::S_IDLE;
      end
      default: state_next = mrm_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mrm_datapath.sv
// Datapath of the Modbus RTU master: transaction state, frame capture,
// CRC, reply checks, shadow register table and result registers. Uses mrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrm_datapath #(
  parameter int TABLE_ENTRIES   = 12,
  parameter int MAX_FRAME_BYTES = 1024
) (
  input  wire                clk,
  input  wire                rst,
  input  mrm_pkg::ctrl_cmd_t cmd,
  output mrm_pkg::dp_stat_t  stat,
  input  wire  [15:0]        join_address,
  input  wire  [15:0]        reply_timeout_ticks,
  input  wire  [2:0]         kind,
  input  wire  [7:0]         dev_code,
  input  wire  [7:0]         fun_code,
  input  wire  [15:0]        reg_address,
  input  wire  [15:0]        write_value,
  input  wire  [7:0]         rx_byte,
  input  wire  [3:0]         entry_index,
  output logic [1:0]         result_kind,
  output logic [7:0]         tx_byte,
  output logic               last_of_run,
  output logic [2:0]         status,
  output logic [15:0]        entry_value,
  output logic               device_joined
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int EXT_W = (IDX_W > 4) ? IDX_W : 4;
  localparam int BC_W  = $clog2(MAX_FRAME_BYTES + 1);

  // Transaction state.
  logic [7:0]       exp_dev;
  logic [7:0]       exp_fun;
  logic [15:0]      exp_addr;
  logic [15:0]      exp_wval;
  logic             awaiting;
  logic [15:0]      tick_count;
  logic [BC_W-1:0]  byte_count;
  logic [7:0]       head [6];
  logic [7:0]       tail [2];
  logic [15:0]      crc_run;
  logic [15:0]      crc_d0;
  logic [15:0]      crc_d1;
  logic [15:0]      tab_addr [TABLE_ENTRIES];
  logic [15:0]      tab_data [TABLE_ENTRIES];
  logic             joined;

  // Request build and search counters.
  logic [15:0]      crc_acc;
  logic [2:0]       crc_cnt;
  logic [2:0]       tx_cnt;
  logic [IDX_W-1:0] srch;
  logic [15:0]      store_data;

  // Result registers.
  logic [1:0]       o_kind;
  logic [2:0]       o_status;
  logic [15:0]      o_value;

  logic [EXT_W-1:0] idx_e;
  logic             idx_ok;
  logic [15:0]      tick_inc;
  logic             expire;
  logic             clear_frame;
  logic [7:0]       crc_src;
  logic [7:0]       tx_src;
  logic [2:0]       chk_code;
  logic             chk_store;
  logic             chk_join;
  logic [15:0]      chk_data;
  logic             hit;
  logic             srch_last;
  logic             rx_take;

  assign idx_e     = EXT_W'(entry_index);
  assign idx_ok    = ({28'd0, entry_index} < 32'(TABLE_ENTRIES));
  assign tick_inc  = tick_count + 16'd1;
  assign expire    = (tick_inc >= reply_timeout_ticks);
  assign hit       = (tab_addr[srch] == exp_addr);
  assign srch_last = (srch == IDX_W'(TABLE_ENTRIES - 1));
  assign rx_take   = cmd.accept && (kind == mrm_pkg::K_RX) && awaiting &&
                     (byte_count < BC_W'(MAX_FRAME_BYTES));

  // Frame capture is dropped on a new request, a finished reply, a timeout
  // and a frame end seen while no reply is pending.
  assign clear_frame = (cmd.accept && (kind == mrm_pkg::K_SEND)) ||
                       (cmd.accept && (kind == mrm_pkg::K_END) && !awaiting) ||
                       (cmd.accept && (kind == mrm_pkg::K_TICK) && awaiting && expire) ||
                       cmd.check;

  // Status toward the controller.
  always_comb begin
    stat.go_crc      = (kind == mrm_pkg::K_SEND);
    stat.go_out      = (kind == mrm_pkg::K_READ) ||
                       ((kind == mrm_pkg::K_TICK) && awaiting && expire);
    stat.go_check    = (kind == mrm_pkg::K_END) && awaiting && (byte_count != '0);
    stat.crc_last    = (crc_cnt == 3'd5);
    stat.tx_last     = (tx_cnt == 3'd7);
    stat.store_req   = chk_store;
    stat.search_done = hit || srch_last;
  end

  // Request bytes, once for the CRC pass and once for transmission.
  function automatic logic [7:0] req_byte(input logic [2:0] sel, input logic [7:0] d,
                                          input logic [7:0] f, input logic [15:0] a,
                                          input logic [15:0] w, input logic [15:0] c);
    logic [7:0] r;
    case (sel)
      3'd0:    r = d;
      3'd1:    r = f;
      3'd2:    r = a[15:8];
      3'd3:    r = a[7:0];
      3'd4:    r = w[15:8];
      3'd5:    r = w[7:0];
      3'd6:    r = c[7:0];
      default: r = c[15:8];
    endcase
    return r;
  endfunction

  assign crc_src = req_byte(crc_cnt, exp_dev, exp_fun, exp_addr, exp_wval, crc_acc);
  assign tx_src  = req_byte(tx_cnt, exp_dev, exp_fun, exp_addr, exp_wval, crc_acc);

  // Reply checks in priority order, then the register rule of the function.
  always_comb begin
    chk_code  = mrm_pkg::ST_OK;
    chk_store = 1'b0;
    chk_join  = 1'b0;
    chk_data  = 16'h0000;
    if (byte_count < BC_W'(4)) begin
      chk_code = mrm_pkg::ST_LENGTH;
    end else if (head[0] != exp_dev) begin
      chk_code = mrm_pkg::ST_DEVICE;
    end else if (head[1] != exp_fun) begin
      chk_code = mrm_pkg::ST_FUNCTION;
    end else if (crc_d1 != {tail[1], tail[0]}) begin
      chk_code = mrm_pkg::ST_CRC;
    end else begin
      case (exp_fun)
        mrm_pkg::FN_READ_COILS: begin
          if (byte_count < BC_W'(6)) chk_code = mrm_pkg::ST_LENGTH;
          else if (head[2] != 8'd1) chk_code = mrm_pkg::ST_MISMATCH;
          else begin
            chk_store = 1'b1;
            chk_data  = {8'h00, head[3]};
          end
        end
        mrm_pkg::FN_READ_HOLD: begin
          if (byte_count < BC_W'(7)) chk_code = mrm_pkg::ST_LENGTH;
          else if (head[2] != 8'd2) chk_code = mrm_pkg::ST_MISMATCH;
          else begin
            chk_store = 1'b1;
            chk_data  = {head[3], head[4]};
          end
        end
        mrm_pkg::FN_WRITE_COIL, mrm_pkg::FN_WRITE_REG: begin
          if (byte_count < BC_W'(8)) chk_code = mrm_pkg::ST_LENGTH;
          else if ({head[2], head[3]} != exp_addr) chk_code = mrm_pkg::ST_MISMATCH;
          else begin
            chk_store = 1'b1;
            chk_join  = (exp_fun == mrm_pkg::FN_WRITE_COIL) && (exp_addr == join_address);
            chk_data  = {head[4], head[5]};
          end
        end
        default: chk_code = mrm_pkg::ST_NOTFOUND;
      endcase
    end
  end

  // State updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_dev    <= '0;
      exp_fun    <= '0;
      exp_addr   <= '0;
      exp_wval   <= '0;
      awaiting   <= 1'b0;
      tick_count <= '0;
      byte_count <= '0;
      head       <= '{default: '0};
      tail       <= '{default: '0};
      crc_run    <= mrm_pkg::CRC_PRESET;
      crc_d0     <= mrm_pkg::CRC_PRESET;
      crc_d1     <= mrm_pkg::CRC_PRESET;
      tab_addr   <= '{default: '0};
      tab_data   <= '{default: '0};
      joined     <= 1'b0;
      crc_acc    <= mrm_pkg::CRC_PRESET;
      crc_cnt    <= '0;
      tx_cnt     <= '0;
      srch       <= '0;
      store_data <= '0;
      o_kind     <= mrm_pkg::R_TX;
      o_status   <= mrm_pkg::ST_OK;
      o_value    <= '0;
    end else begin
      // Collected frame.
      if (clear_frame) begin
        byte_count <= '0;
        head       <= '{default: '0};
        tail       <= '{default: '0};
        crc_run    <= mrm_pkg::CRC_PRESET;
        crc_d0     <= mrm_pkg::CRC_PRESET;
        crc_d1     <= mrm_pkg::CRC_PRESET;
      end else if (rx_take) begin
        if (byte_count < BC_W'(6)) head[byte_count[2:0]] <= rx_byte;
        tail[0]    <= tail[1];
        tail[1]    <= rx_byte;
        crc_d1     <= crc_d0;
        crc_d0     <= crc_run;
        crc_run    <= mrm_pkg::crc_step(crc_run, rx_byte);
        byte_count <= byte_count + BC_W'(1);
      end

      // Accepted input words.
      if (cmd.accept) begin
        case (kind)
          mrm_pkg::K_SEND: begin
            exp_dev    <= dev_code;
            exp_fun    <= fun_code;
            exp_addr   <= reg_address;
            exp_wval   <= write_value;
            awaiting   <= 1'b1;
            tick_count <= '0;
            crc_acc    <= mrm_pkg::CRC_PRESET;
            crc_cnt    <= '0;
            tx_cnt     <= '0;
            o_kind     <= mrm_pkg::R_TX;
            o_status   <= mrm_pkg::ST_OK;
            o_value    <= '0;
          end
          mrm_pkg::K_TICK: begin
            if (awaiting) begin
              if (expire) begin
                awaiting   <= 1'b0;
                tick_count <= '0;
                o_kind     <= mrm_pkg::R_STATUS;
                o_status   <= mrm_pkg::ST_TIMEOUT;
                o_value    <= '0;
              end else begin
                tick_count <= tick_inc;
              end
            end
          end
          mrm_pkg::K_LOAD: begin
            if (idx_ok) tab_addr[idx_e[IDX_W-1:0]] <= reg_address;
          end
          mrm_pkg::K_READ: begin
            o_kind   <= mrm_pkg::R_DATA;
            o_status <= mrm_pkg::ST_OK;
            o_value  <= idx_ok ? tab_data[idx_e[IDX_W-1:0]] : 16'h0000;
          end
          default: ;
        endcase
      end

      // Request CRC, one byte a cycle.
      if (cmd.crc_en) begin
        crc_acc <= mrm_pkg::crc_step(crc_acc, crc_src);
        crc_cnt <= crc_cnt + 3'd1;
      end

      if (cmd.tx_next) tx_cnt <= tx_cnt + 3'd1;

      // Reply check closes the transaction.
      if (cmd.check) begin
        awaiting   <= 1'b0;
        tick_count <= '0;
        srch       <= '0;
        store_data <= chk_data;
        o_kind     <= mrm_pkg::R_STATUS;
        o_status   <= chk_code;
        o_value    <= '0;
        if (chk_join) joined <= 1'b1;
      end

      // Table search, one entry a cycle, first match wins.
      if (cmd.search) begin
        if (hit) begin
          tab_data[srch] <= store_data;
          o_status       <= mrm_pkg::ST_OK;
        end else if (srch_last) begin
          o_status <= mrm_pkg::ST_NOTFOUND;
        end else begin
          srch <= srch + IDX_W'(1);
        end
      end
    end
  end

  // Result word.
  assign result_kind   = o_kind;
  assign tx_byte       = (o_kind == mrm_pkg::R_TX) ? tx_src : 8'h00;
  assign last_of_run   = (o_kind == mrm_pkg::R_TX) && (tx_cnt == 3'd7);
  assign status        = o_status;
  assign entry_value   = o_value;
  assign device_joined = joined;

endmodule

`default_nettype wire

FILE: hw/rtl/mrm_checker.sv
// Port checker of the Modbus RTU master and its bind to the top level.
// Uses the assertion macros of modbus_rtu_master_transaction_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "modbus_rtu_master_transaction_defines.svh"

module mrm_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_stall,
  input wire       out_valid,
  input wire       out_stall,
  input wire [1:0] result_kind,
  input wire       last_of_run
);

  // A waiting result word is not dropped.
  `MRM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)

  // No input word is taken while a result word is offered.
  `MRM_ASSERT(a_busy_in, out_valid |-> in_stall)

  // The end-of-run mark only appears on transmit words.
  `MRM_ASSERT(a_last_tx, out_valid && last_of_run |-> result_kind == mrm_pkg::R_TX)

  // No result word in the cycle after a reset cycle.
  `MRM_ASSERT_ALWAYS(a_reset_quiet, rst |=> !out_valid)

endmodule

bind modbus_rtu_master_transaction mrm_checker u_mrm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .result_kind (result_kind),
  .last_of_run (last_of_run)
);

`default_nettype wire

FILE: sim/tb_modbus_rtu_master_transaction.sv
// Testbench of the Modbus RTU master transaction block.
// Drives request, reply and table words, predicts every result word and checks it.
// Depends on mrm_pkg and modbus_rtu_master_transaction.
`timescale 1ns / 1ps

module tb_modbus_rtu_master_transaction;

  localparam int N_ENTRIES = 12;
  localparam int FRAME_MAX = 1024;
  localparam int HOLD_LEN  = 400;

  typedef struct packed {
    logic [1:0]  rk;
    logic [7:0]  tx;
    logic        last;
    logic [2:0]  st;
    logic [15:0] val;
    logic        joined;
  } reply_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] kind = '0;
  logic [7:0] dev_code = '0, fun_code = '0, rx_byte = '0;
  logic [15:0] reg_address = '0, write_value = '0;
  logic [3:0] entry_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] result_kind;
  logic [7:0] tx_byte;
  logic last_of_run;
  logic [2:0] status;
  logic [15:0] entry_value;
  logic device_joined;

  modbus_rtu_master_transaction uut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Shadow state of the master.
  logic [15:0] m_join, m_timeout;
  logic [7:0]  m_dev, m_fun;
  logic [15:0] m_addr;
  logic        m_wait;
  logic [15:0] m_ticks;
  int          m_count;
  logic [7:0]  m_head [6];
  logic [7:0]  m_tail [2];
  logic [15:0] m_crc, m_crc1, m_crc2;
  logic [15:0] m_tab_addr [N_ENTRIES];
  logic [15:0] m_tab_data [N_ENTRIES];
  logic        m_joined;

  reply_word_t pending_words[$];
  int errors = 0;
  int mismatches = 0;

  // Idle behavior knobs. A toggle of hold_go asks the receiver for a long hold-off.
  bit quiet_mode = 1'b0;
  bit hold_go = 1'b0;
  bit hold_ack = 1'b0;
  int hold_cycles = 0;

  function automatic logic [15:0] modbus_crc(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    return r;
  endfunction

  function automatic void clear_frame();
    m_count = 0;
    for (int i = 0; i < 6; i++) m_head[i] = 8'h00;
    m_tail[0] = 8'h00;
    m_tail[1] = 8'h00;
    m_crc = 16'hFFFF;
    m_crc1 = 16'hFFFF;
    m_crc2 = 16'hFFFF;
  endfunction

  function automatic void reset_shadow();
    m_join = 16'd0;
    m_timeout = 16'd50;
    m_dev = 8'd0;
    m_fun = 8'd0;
    m_addr = 16'd0;
    m_wait = 1'b0;
    m_ticks = 16'd0;
    clear_frame();
    for (int i = 0; i < N_ENTRIES; i++) begin
      m_tab_addr[i] = 16'd0;
      m_tab_data[i] = 16'd0;
    end
    m_joined = 1'b0;
  endfunction

  function automatic void push_word(logic [1:0] rk, logic [7:0] tx, logic last,
                                    logic [2:0] st, logic [15:0] val);
    reply_word_t w;
    w.rk = rk;
    w.tx = tx;
    w.last = last;
    w.st = st;
    w.val = val;
    w.joined = m_joined;
    pending_words.push_back(w);
  endfunction

  function automatic logic [2:0] store_entry(logic [15:0] a, logic [15:0] d);
    for (int i = 0; i < N_ENTRIES; i++) begin
      if (m_tab_addr[i] == a) begin
        m_tab_data[i] = d;
        return mrm_pkg::ST_OK;
      end
    end
    return mrm_pkg::ST_NOTFOUND;
  endfunction

  function automatic logic [2:0] judge_frame();
    int len;
    logic [15:0] echo;
    if (m_count < 4) return mrm_pkg::ST_LENGTH;
    if (m_head[0] != m_dev) return mrm_pkg::ST_DEVICE;
    if (m_head[1] != m_fun) return mrm_pkg::ST_FUNCTION;
    if (m_crc2 != {m_tail[1], m_tail[0]}) return mrm_pkg::ST_CRC;
    len = m_count - 4;
    case (m_fun)
      mrm_pkg::FN_READ_COILS: begin
        if (len < 2) return mrm_pkg::ST_LENGTH;
        if (m_head[2] != 8'd1) return mrm_pkg::ST_MISMATCH;
        return store_entry(m_addr, {8'h00, m_head[3]});
      end
      mrm_pkg::FN_READ_HOLD: begin
        if (len < 3) return mrm_pkg::ST_LENGTH;
        if (m_head[2] != 8'd2) return mrm_pkg::ST_MISMATCH;
        return store_entry(m_addr, {m_head[3], m_head[4]});
      end
      mrm_pkg::FN_WRITE_COIL, mrm_pkg::FN_WRITE_REG: begin
        if (len < 4) return mrm_pkg::ST_LENGTH;
        echo = {m_head[2], m_head[3]};
        if (echo != m_addr) return mrm_pkg::ST_MISMATCH;
        if (m_fun == mrm_pkg::FN_WRITE_COIL && m_addr == m_join) m_joined = 1'b1;
        return store_entry(m_addr, {m_head[4], m_head[5]});
      end
      default: return mrm_pkg::ST_NOTFOUND;
    endcase
  endfunction

  // Predicts the result words of one accepted input word.
  function automatic void predict_word(logic [2:0] k, logic [7:0] d, logic [7:0] f,
                                       logic [15:0] a, logic [15:0] v, logic [7:0] b,
                                       logic [3:0] idx);
    logic [7:0] req [8];
    logic [15:0] c;
    logic [2:0] st;
    case (k)
      mrm_pkg::K_SEND: begin
        m_dev = d;
        m_fun = f;
        m_addr = a;
        m_wait = 1'b1;
        m_ticks = 16'd0;
        clear_frame();
        req[0] = d;
        req[1] = f;
        req[2] = a[15:8];
        req[3] = a[7:0];
        req[4] = v[15:8];
        req[5] = v[7:0];
        c = 16'hFFFF;
        for (int i = 0; i < 6; i++) c = modbus_crc(c, req[i]);
        req[6] = c[7:0];
        req[7] = c[15:8];
        for (int i = 0; i < 8; i++) begin
          push_word(mrm_pkg::R_TX, req[i], i == 7, mrm_pkg::ST_OK, 16'd0);
        end
      end
      mrm_pkg::K_RX: begin
        if (m_wait && m_count < FRAME_MAX) begin
          if (m_count < 6) m_head[m_count] = b;
          m_tail[0] = m_tail[1];
          m_tail[1] = b;
          m_crc2 = m_crc1;
          m_crc1 = m_crc;
          m_crc = modbus_crc(m_crc, b);
          m_count++;
        end
      end
      mrm_pkg::K_END: begin
        if (!m_wait) begin
          clear_frame();
        end else if (m_count != 0) begin
          st = judge_frame();
          m_wait = 1'b0;
          m_ticks = 16'd0;
          clear_frame();
          push_word(mrm_pkg::R_STATUS, 8'd0, 1'b0, st, 16'd0);
        end
      end
      mrm_pkg::K_TICK: begin
        if (m_wait) begin
          m_ticks++;
          if (m_ticks >= m_timeout) begin
            m_wait = 1'b0;
            m_ticks = 16'd0;
            clear_frame();
            push_word(mrm_pkg::R_STATUS, 8'd0, 1'b0, mrm_pkg::ST_TIMEOUT, 16'd0);
          end
        end
      end
      mrm_pkg::K_LOAD: begin
        if (idx < N_ENTRIES) m_tab_addr[idx] = a;
      end
      mrm_pkg::K_READ: begin
        push_word(mrm_pkg::R_DATA, 8'd0, 1'b0, mrm_pkg::ST_OK,
                  (idx < N_ENTRIES) ? m_tab_data[idx] : 16'd0);
      end
      default: ;
    endcase
  endfunction

  // Sends one word, with a random idle gap, and waits for its acceptance.
  // The word stays offered until the next word or a drain replaces it.
  task automatic send_word(logic [2:0] k, logic [7:0] d, logic [7:0] f,
                           logic [15:0] a, logic [15:0] v, logic [7:0] b,
                           logic [3:0] idx);
    while (!quiet_mode && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    kind <= k;
    dev_code <= d;
    fun_code <= f;
    reg_address <= a;
    write_value <= v;
    rx_byte <= b;
    entry_index <= idx;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(k, d, f, a, v, b, idx);
    @(negedge clk);
  endtask

  task automatic send_kind(logic [2:0] k);
    send_word(k, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
              8'($urandom), 4'($urandom));
  endtask

  task automatic send_request(logic [7:0] d, logic [7:0] f, logic [15:0] a,
                              logic [15:0] v);
    send_word(mrm_pkg::K_SEND, d, f, a, v, 8'($urandom), 4'($urandom));
  endtask

  task automatic send_rx(logic [7:0] b);
    send_word(mrm_pkg::K_RX, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
              b, 4'($urandom));
  endtask

  task automatic load_entry(logic [3:0] idx, logic [15:0] a);
    send_word(mrm_pkg::K_LOAD, 8'($urandom), 8'($urandom), a, 16'($urandom),
              8'($urandom), idx);
  endtask

  task automatic read_entry(logic [3:0] idx);
    send_word(mrm_pkg::K_READ, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
              8'($urandom), idx);
  endtask

  // Sends a reply frame; the payload CRC is appended, optionally corrupted.
  task automatic send_reply(logic [7:0] bytes [$], bit bad_crc);
    logic [15:0] c;
    c = 16'hFFFF;
    foreach (bytes[i]) begin
      c = modbus_crc(c, bytes[i]);
      send_rx(bytes[i]);
    end
    if (bad_crc) c = c ^ (16'd1 << $urandom_range(15));
    send_rx(c[7:0]);
    send_rx(c[15:8]);
    send_kind(mrm_pkg::K_END);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic apb_write(logic [2:0] a, logic [15:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= {16'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (a == mrm_pkg::A_JOIN) m_join = v;
    else m_timeout = v;
  endtask

  // Receiver side: random stalls plus a long hold-off when asked.
  always @(negedge clk) begin
    if (hold_go != hold_ack) begin
      hold_ack <= hold_go;
      hold_cycles <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet_mode && ($urandom_range(99) < 26);
    end
  end

  // Checks each accepted result word against the oldest prediction.
  always @(posedge clk) begin
    reply_word_t w, got;
    if (!rst && out_valid && !out_stall) begin
      got = {result_kind, tx_byte, last_of_run, status, entry_value, device_joined};
      if (pending_words.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected word %h", got);
        mismatches++;
      end else begin
        w = pending_words.pop_front();
        if (w != got) begin
          errors++;
          if (mismatches < 10) begin
            $display("mismatch: expected kind %0d tx %h last %0d st %0d val %h j %0d",
                     w.rk, w.tx, w.last, w.st, w.val, w.joined);
            $display("          got      kind %0d tx %h last %0d st %0d val %h j %0d",
                     got.rk, got.tx, got.last, got.st, got.val, got.joined);
          end
          mismatches++;
        end
      end
    end
  end

  task automatic one_reply(logic [7:0] fn, logic [15:0] a, bit good);
    logic [7:0] q [$];
    logic [7:0] d;
    d = 8'($urandom);
    send_request(d, fn, a, 16'($urandom));
    q.push_back(good || $urandom_range(3) != 0 ? d : d ^ 8'h01);
    q.push_back(good || $urandom_range(3) != 0 ? fn : fn ^ 8'h80);
    case (fn)
      mrm_pkg::FN_READ_COILS: begin
        q.push_back(good ? 8'd1 : 8'($urandom_range(2)));
        q.push_back(8'($urandom));
      end
      mrm_pkg::FN_READ_HOLD: begin
        q.push_back(good ? 8'd2 : 8'($urandom_range(3)));
        q.push_back(8'($urandom));
        q.push_back(8'($urandom));
      end
      mrm_pkg::FN_WRITE_COIL, mrm_pkg::FN_WRITE_REG: begin
        q.push_back(a[15:8]);
        q.push_back(good || $urandom_range(1) != 0 ? a[7:0] : a[7:0] ^ 8'h04);
        q.push_back(8'($urandom));
        q.push_back(8'($urandom));
      end
      default: q.push_back(8'($urandom));
    endcase
    if (!good && $urandom_range(3) == 0) void'(q.pop_back());
    send_reply(q, !good && $urandom_range(3) == 0);
  endtask

  task automatic test_directed();
    for (int i = 0; i < N_ENTRIES; i++) load_entry(4'(i), 16'(16'h0100 + i));
    load_entry(4'd15, 16'hFFFF);
    send_request(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(8'h00, 8'h00, 16'h0000, 16'h0000);
    send_rx(8'h11);
    send_kind(mrm_pkg::K_END);
    one_reply(mrm_pkg::FN_READ_HOLD, 16'h0102, 1'b1);
    one_reply(mrm_pkg::FN_WRITE_COIL, 16'h0000, 1'b1);
    one_reply(mrm_pkg::FN_READ_COILS, 16'h0105, 1'b1);
    one_reply(mrm_pkg::FN_WRITE_REG, 16'h0103, 1'b1);
    one_reply(8'd17, 16'h0103, 1'b1);
    send_kind(mrm_pkg::K_END);
    send_rx(8'hAA);
    send_kind(3'd6);
    send_kind(3'd7);
    read_entry(4'd2);
    read_entry(4'd12);
    read_entry(4'd15);
    wait_drained();
  endtask

  task automatic test_config();
    apb_write(mrm_pkg::A_JOIN, 16'h0104);
    apb_write(mrm_pkg::A_TIMEOUT, 16'd0);
    send_request(8'h01, mrm_pkg::FN_WRITE_COIL, 16'h0104, 16'hFF00);
    send_kind(mrm_pkg::K_TICK);
    one_reply(mrm_pkg::FN_WRITE_COIL, 16'h0104, 1'b1);
    read_entry(4'd4);
    wait_drained();
    apb_write(mrm_pkg::A_TIMEOUT, 16'd3);
    send_request(8'h02, mrm_pkg::FN_READ_HOLD, 16'h0001, 16'h0001);
    send_kind(mrm_pkg::K_END);
    repeat (3) send_kind(mrm_pkg::K_TICK);
    wait_drained();
    apb_write(mrm_pkg::A_JOIN, 16'hFFFF);
    apb_write(mrm_pkg::A_TIMEOUT, 16'hFFFF);
    wait_drained();
  endtask

  task automatic test_random(int n);
    int r;
    logic [15:0] a;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      a = ($urandom_range(1) != 0) ? 16'(16'h0100 + $urandom_range(13)) : 16'($urandom);
      if (r < 45) begin
        one_reply($urandom_range(3) == 0 ? mrm_pkg::FN_READ_COILS :
                  $urandom_range(2) == 0 ? mrm_pkg::FN_READ_HOLD :
                  $urandom_range(1) != 0 ? mrm_pkg::FN_WRITE_COIL : mrm_pkg::FN_WRITE_REG,
                  a, $urandom_range(2) != 0);
      end else if (r < 55) begin
        one_reply(8'($urandom), a, $urandom_range(1) != 0);
      end else if (r < 65) begin
        load_entry(4'($urandom_range(15)), a);
      end else if (r < 78) begin
        read_entry(4'($urandom_range(15)));
      end else if (r < 88) begin
        send_kind(mrm_pkg::K_TICK);
      end else begin
        send_kind(3'($urandom_range(7)));
      end
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_go = ~hold_go;
    for (int i = 0; i < 4; i++) begin
      send_request(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
    end
    wait_drained();
    quiet_mode = 1'b1;
    apb_write(mrm_pkg::A_TIMEOUT, 16'd2);
    for (int i = 0; i < 10; i++) begin
      one_reply(mrm_pkg::FN_READ_HOLD, 16'(16'h0100 + i), 1'b1);
    end
    send_request(8'h05, mrm_pkg::FN_READ_HOLD, 16'h0001, 16'h0001);
    send_kind(mrm_pkg::K_TICK);
    send_kind(mrm_pkg::K_TICK);
    wait_drained();
    quiet_mode = 1'b0;
    apb_write(mrm_pkg::A_TIMEOUT, 16'd40);
    apb_write(mrm_pkg::A_JOIN, 16'h0107);
  endtask

  initial begin
    reset_shadow();
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_config();
    test_random(27);
    test_backpressure();
    test_random(27);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule

FILE: modbus_rtu_master_transaction.f
+incdir+hw/rtl
hw/rtl/mrm_pkg.sv
hw/rtl/mrm_ctrl.sv
hw/rtl/mrm_datapath.sv
hw/rtl/modbus_rtu_master_transaction.sv
hw/rtl/mrm_checker.sv
sim/tb_modbus_rtu_master_transaction.sv
